// ===== rtl/serial_command_pwm_adjuster_defines.svh =====
// Assertion macros for the checker file of the serial command PWM adjuster.
// Needs nothing else; include by bare file name.
`ifndef SERIAL_COMMAND_PWM_ADJUSTER_DEFINES_SVH
`define SERIAL_COMMAND_PWM_ADJUSTER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SCPA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("scpa assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define SCPA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("scpa assertion failed");

`endif

// ===== rtl/scpa_pkg.sv =====
// Package for the serial command PWM adjuster: command codes, register indexes,
// reset values and the structs passed between its modules. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package scpa_pkg;

    localparam logic [7:0] TERMINATOR   = 8'h2E;  // '.'
    localparam logic [7:0] CHAR_S       = 8'h53;  // 'S'
    localparam logic [7:0] CHAR_W       = 8'h57;  // 'W'
    localparam logic [7:0] CHAR_ONE     = 8'h31;  // '1'
    localparam logic [7:0] CHAR_THREE   = 8'h33;  // '3'
    localparam logic [7:0] CHAR_NUL     = 8'h00;

    localparam int PREFIX_LEN   = 4;
    localparam int PREFIX_IDX_W = 2;

    localparam int LEVEL_W     = 16;
    localparam int CMD_W       = 2;
    localparam int OUT_FIELD_W = CMD_W + 2 * LEVEL_W;
    localparam int OUT_DATA_W  = ((OUT_FIELD_W + 7) / 8) * 8;
    localparam int CFG_INDEX_W = 2;

    // floor(x / 10) == (x * 52429) >> 19 for every 16 bit x
    localparam logic [16:0] TENTH_MULT  = 17'd52429;
    localparam int          TENTH_SHIFT = 19;

    localparam logic [LEVEL_W-1:0] PERIOD_SLOW_RST = 16'd3999;
    localparam logic [LEVEL_W-1:0] DUTY_SLOW_RST   = 16'd1999;
    localparam logic [LEVEL_W-1:0] PERIOD_FAST_RST = 16'd1999;
    localparam logic [LEVEL_W-1:0] DUTY_FAST_RST   = 16'd999;

    typedef enum logic [CMD_W-1:0] {
        CMD_INVALID = 2'd0,
        CMD_RAISE   = 2'd1,
        CMD_LOWER   = 2'd2,
        CMD_TOGGLE  = 2'd3
    } cmd_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_PERIOD_SLOW = 2'd0,
        REG_DUTY_SLOW   = 2'd1,
        REG_PERIOD_FAST = 2'd2,
        REG_DUTY_FAST   = 2'd3
    } reg_index_t;

    typedef struct packed {
        logic                   valid;
        logic [CFG_INDEX_W-1:0] index;
        logic [LEVEL_W-1:0]     data;
    } cfg_write_t;

    typedef struct packed {
        logic       valid;
        logic [7:0] data;
    } text_req_t;

    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } level_req_t;

endpackage

`default_nettype wire

// ===== rtl/scpa_text.sv =====
// Command text gatherer: keeps the first four bytes, the saturating length and
// the zero-byte flag, and decodes the command. Depends on scpa_pkg.
`timescale 1ns / 1ps
`default_nettype none

module scpa_text #(
    parameter int BUFFER_DEPTH = 16
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire scpa_pkg::text_req_t req,
    output scpa_pkg::cmd_t         cmd
);

    localparam int LEN_W = $clog2(BUFFER_DEPTH + 1);

    logic [7:0]       prefix_reg  [scpa_pkg::PREFIX_LEN];
    logic [7:0]       prefix_next [scpa_pkg::PREFIX_LEN];
    logic [LEN_W-1:0] len_reg;
    logic [LEN_W-1:0] len_next;
    logic             zero_reg;
    logic             zero_next;
    logic             ends_at_three;
    logic             name_ok;

    always_comb
    begin
        prefix_next = prefix_reg;
        len_next    = len_reg;
        zero_next   = zero_reg;
        if (req.valid)
        begin
            if (req.data == scpa_pkg::TERMINATOR)
            begin
                // drop the gathered text after every terminator
                for (int i = 0; i < scpa_pkg::PREFIX_LEN; i++)
                begin
                    prefix_next[i] = scpa_pkg::CHAR_NUL;
                end
                len_next  = '0;
                zero_next = 1'b0;
            end
            else
            begin
                if (len_reg < LEN_W'(scpa_pkg::PREFIX_LEN))
                begin
                    prefix_next[len_reg[scpa_pkg::PREFIX_IDX_W-1:0]] = req.data;
                    if (req.data == scpa_pkg::CHAR_NUL)
                    begin
                        zero_next = 1'b1;
                    end
                end
                if (len_reg < LEN_W'(BUFFER_DEPTH))
                begin
                    len_next = len_reg + LEN_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < scpa_pkg::PREFIX_LEN; i++)
            begin
                prefix_reg[i] <= scpa_pkg::CHAR_NUL;
            end
            len_reg  <= '0;
            zero_reg <= 1'b0;
        end
        else
        begin
            prefix_reg <= prefix_next;
            len_reg    <= len_next;
            zero_reg   <= zero_next;
        end
    end

    // text must stop right after the digit: three bytes, or a zero in the fourth place
    assign ends_at_three = (len_reg == LEN_W'(3)) ||
                           ((len_reg > LEN_W'(3)) && zero_reg &&
                            (prefix_reg[3] == scpa_pkg::CHAR_NUL));

    assign name_ok = (len_reg < LEN_W'(BUFFER_DEPTH)) &&
                     (prefix_reg[0] == scpa_pkg::CHAR_S) &&
                     (prefix_reg[1] == scpa_pkg::CHAR_W) &&
                     (prefix_reg[2] >= scpa_pkg::CHAR_ONE) &&
                     (prefix_reg[2] <= scpa_pkg::CHAR_THREE) &&
                     ends_at_three;

    // digits '1'..'3' carry the command code in their two low bits
    assign cmd = name_ok ? scpa_pkg::cmd_t'(prefix_reg[2][scpa_pkg::CMD_W-1:0])
                         : scpa_pkg::CMD_INVALID;

endmodule

`default_nettype wire

// ===== rtl/scpa_level.sv =====
// PWM level keeper: configuration registers, compare value, period top and the
// slow/fast toggle, with the next values after a command. Depends on scpa_pkg.
`timescale 1ns / 1ps
`default_nettype none

module scpa_level (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire scpa_pkg::cfg_write_t cfg,
    input  wire scpa_pkg::level_req_t req,
    output logic [scpa_pkg::LEVEL_W-1:0] duty_next,
    output logic [scpa_pkg::LEVEL_W-1:0] period_next
);

    localparam int W = scpa_pkg::LEVEL_W;

    logic [W-1:0] period_slow_reg;
    logic [W-1:0] duty_slow_reg;
    logic [W-1:0] period_fast_reg;
    logic [W-1:0] duty_fast_reg;
    logic [W-1:0] duty_reg;
    logic [W-1:0] period_reg;
    logic         fast_reg;
    logic         fast_next;

    logic [W+16:0] tenth_prod;
    logic [W-1:0]  tenth;
    logic [W:0]    raise_sum;
    logic [W-1:0]  raise_val;
    logic [W-1:0]  lower_val;

    assign tenth_prod = duty_reg * scpa_pkg::TENTH_MULT;
    assign tenth      = W'(tenth_prod >> scpa_pkg::TENTH_SHIFT);
    assign raise_sum  = {1'b0, duty_reg} + {1'b0, tenth};
    assign raise_val  = (raise_sum >= {1'b0, period_reg}) ? period_reg : raise_sum[W-1:0];
    assign lower_val  = duty_reg - tenth;

    always_comb
    begin
        duty_next   = duty_reg;
        period_next = period_reg;
        fast_next   = fast_reg;
        case (req.cmd)
            scpa_pkg::CMD_RAISE:
            begin
                duty_next = raise_val;
            end
            scpa_pkg::CMD_LOWER:
            begin
                duty_next = lower_val;
            end
            scpa_pkg::CMD_TOGGLE:
            begin
                fast_next = !fast_reg;
                if (!fast_reg)
                begin
                    period_next = period_fast_reg;
                    duty_next   = duty_fast_reg;
                end
                else
                begin
                    period_next = period_slow_reg;
                    duty_next   = duty_slow_reg;
                end
            end
            default:
            begin
                duty_next = duty_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_slow_reg <= scpa_pkg::PERIOD_SLOW_RST;
            duty_slow_reg   <= scpa_pkg::DUTY_SLOW_RST;
            period_fast_reg <= scpa_pkg::PERIOD_FAST_RST;
            duty_fast_reg   <= scpa_pkg::DUTY_FAST_RST;
        end
        else if (cfg.valid)
        begin
            unique case (scpa_pkg::reg_index_t'(cfg.index))
                scpa_pkg::REG_PERIOD_SLOW: period_slow_reg <= cfg.data;
                scpa_pkg::REG_DUTY_SLOW:   duty_slow_reg   <= cfg.data;
                scpa_pkg::REG_PERIOD_FAST: period_fast_reg <= cfg.data;
                scpa_pkg::REG_DUTY_FAST:   duty_fast_reg   <= cfg.data;
                default:                   period_slow_reg <= period_slow_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            duty_reg   <= scpa_pkg::DUTY_SLOW_RST;
            period_reg <= scpa_pkg::PERIOD_SLOW_RST;
            fast_reg   <= 1'b0;
        end
        else if (req.valid)
        begin
            duty_reg   <= duty_next;
            period_reg <= period_next;
            fast_reg   <= fast_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/serial_command_pwm_adjuster.sv =====
// Top level of the serial command PWM adjuster: input register, result register
// and handshakes. Depends on scpa_pkg, scpa_text and scpa_level.
`timescale 1ns / 1ps
`default_nettype none

//  channel   direction  payload                                   request moves
//  s_axis    in         tdata[7:0] rx_byte                        one received byte
//  m_axis    out        tdata command, duty_compare, period_top   one result per '.'
//  cfg       in         cfg_index, cfg_data                       one register write
//
//  A byte is taken every cycle unless a terminator waits in the input register
//  for a free result slot; each request passes through the input register, and a
//  terminator's result is written to the result register as the terminator leaves.
//  The compare update is a 16x17 multiply by the reciprocal of ten, then an add
//  with a clamp compare or a subtract. Reset (rst_n low, asynchronous) clears the
//  text, loads the slow pair and the register defaults; no clearing pass is needed.
//  A stalled result holds back a terminator waiting behind it and the bytes after it.

module serial_command_pwm_adjuster #(
    parameter int BUFFER_DEPTH = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // slave stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    // master stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [scpa_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    // m_axis_tdata: [1:0] command, [17:2] duty_compare, [33:18] period_top, [39:34] zero
    // configuration write
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [scpa_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [scpa_pkg::LEVEL_W-1:0]     cfg_data
);

    localparam int PAD_W = scpa_pkg::OUT_DATA_W - scpa_pkg::OUT_FIELD_W;

    logic       in_valid_reg;
    logic       in_valid_next;
    logic [7:0] in_byte_reg;
    logic       in_is_term;
    logic       in_advance;
    logic       s_accept;

    logic                            out_valid_reg;
    logic                            out_valid_next;
    logic [scpa_pkg::OUT_DATA_W-1:0] out_data_reg;

    scpa_pkg::text_req_t  text_req;
    scpa_pkg::level_req_t level_req;
    scpa_pkg::cfg_write_t cfg_wr;
    scpa_pkg::cmd_t       cmd;
    logic [scpa_pkg::LEVEL_W-1:0] duty_next;
    logic [scpa_pkg::LEVEL_W-1:0] period_next;

    // ordinary bytes always advance; a terminator waits for a free result slot
    assign in_is_term    = (in_byte_reg == scpa_pkg::TERMINATOR);
    assign in_advance    = in_valid_reg && (!in_is_term || !out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || in_advance;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (in_advance)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    // hold the byte payload
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            in_byte_reg <= s_axis_tdata;
        end
    end

    assign text_req.valid  = in_advance;
    assign text_req.data   = in_byte_reg;
    assign level_req.valid = in_advance && in_is_term;
    assign level_req.cmd   = cmd;

    // configuration writes are always taken
    assign cfg_ready    = 1'b1;
    assign cfg_wr.valid = cfg_valid;
    assign cfg_wr.index = cfg_index;
    assign cfg_wr.data  = cfg_data;

    scpa_text #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_text (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (text_req),
        .cmd   (cmd)
    );

    scpa_level u_level (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_wr),
        .req         (level_req),
        .duty_next   (duty_next),
        .period_next (period_next)
    );

    // result slot: fill on a terminator, drain when the sink takes it
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (level_req.valid)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (level_req.valid)
        begin
            out_data_reg <= {{PAD_W{1'b0}}, period_next, duty_next, cmd};
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

`default_nettype wire

// ===== rtl/scpa_checker.sv =====
// Port-level checker for the serial command PWM adjuster and its bind statement.
// Depends on scpa_pkg and serial_command_pwm_adjuster_defines.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "serial_command_pwm_adjuster_defines.svh"

module scpa_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic [7:0]  s_axis_tdata,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [scpa_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input wire logic        cfg_valid,
    input wire logic        cfg_ready,
    input wire logic [scpa_pkg::CFG_INDEX_W-1:0] cfg_index,
    input wire logic [scpa_pkg::LEVEL_W-1:0]     cfg_data
);

    logic [scpa_pkg::CMD_W-1:0]   out_cmd;
    logic [scpa_pkg::LEVEL_W-1:0] out_duty;
    logic [scpa_pkg::LEVEL_W-1:0] out_period;
    logic                         in_unused;

    assign out_cmd    = m_axis_tdata[1:0];
    assign out_duty   = m_axis_tdata[17:2];
    assign out_period = m_axis_tdata[33:18];
    assign in_unused  = s_axis_tvalid ^ (^s_axis_tdata) ^ cfg_valid ^ cfg_ready ^
                        (^cfg_index) ^ (^cfg_data);

    // a stalled result holds
    `SCPA_ASSERT_NEXT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata))

    // a raise never leaves the compare value above the period top
    `SCPA_ASSERT_NOW(a_raise_clamped, clk, rst_n,
        m_axis_tvalid && (out_cmd == scpa_pkg::CMD_RAISE), out_duty <= out_period)

    // a ready sink never throttles the byte stream
    `SCPA_ASSERT_NOW(a_no_throttle, clk, rst_n, m_axis_tready, s_axis_tready)

    // padding above the result fields stays zero
    `SCPA_ASSERT_NOW(a_pad_zero, clk, rst_n, m_axis_tvalid || in_unused || !in_unused,
        !m_axis_tvalid || (m_axis_tdata[scpa_pkg::OUT_DATA_W-1:scpa_pkg::OUT_FIELD_W] == '0))

endmodule

bind serial_command_pwm_adjuster scpa_checker u_scpa_checker (.*);

`default_nettype wire
